>>> rtl/core/chacha20_stream_xor_top_assert.svh
// Assertion macros shared by the RTL; clk and rst_n come from the using module.
`ifndef CHACHA20_STREAM_XOR_TOP_ASSERT_SVH
`define CHACHA20_STREAM_XOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define CC20_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CC20_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/cc20_pkg.sv
package cc20_pkg;

  localparam int DOUBLE_ROUNDS  = 10;
  localparam int ROUNDS         = 2 * DOUBLE_ROUNDS;
  localparam int ROUND_W        = $clog2(ROUNDS);
  localparam int BYTES_PER_ITEM = 8;
  localparam int DATA_BYTES     = 8;
  localparam int BLOCK_BYTES    = 64;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  typedef logic [15:0][31:0] word_arr_t;

  typedef enum logic [2:0] {
    CFG_KEY_LOW      = 3'd0,
    CFG_KEY_MID_LOW  = 3'd1,
    CFG_KEY_MID_HIGH = 3'd2,
    CFG_KEY_HIGH     = 3'd3,
    CFG_NONCE_LOW    = 3'd4,
    CFG_NONCE_HIGH   = 3'd5,
    CFG_INIT_CTR     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } core_sts_t;

endpackage

>>> rtl/core/cc20_qr.sv
module cc20_qr
  import cc20_pkg::*;
(
  input  logic [31:0] a_in,
  input  logic [31:0] b_in,
  input  logic [31:0] c_in,
  input  logic [31:0] d_in,
  output logic [31:0] a_out,
  output logic [31:0] b_out,
  output logic [31:0] c_out,
  output logic [31:0] d_out
);

  logic [31:0] a1, b1, c1, d1, a2, b2, c2, d2;
  logic [31:0] dx1, bx1, dx2, bx2;

  always_comb begin
    a1    = a_in + b_in;
    dx1   = d_in ^ a1;
    d1    = {dx1[15:0], dx1[31:16]};
    c1    = c_in + d1;
    bx1   = b_in ^ c1;
    b1    = {bx1[19:0], bx1[31:20]};
    a2    = a1 + b1;
    dx2   = d1 ^ a2;
    d2    = {dx2[23:0], dx2[31:24]};
    c2    = c1 + d2;
    bx2   = b1 ^ c2;
    b2    = {bx2[24:0], bx2[31:25]};
    a_out = a2;
    b_out = b2;
    c_out = c2;
    d_out = d2;
  end

endmodule

>>> rtl/core/cc20_core.sv
module cc20_core
  import cc20_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  word_arr_t init_words,
  output core_sts_t sts,
  output word_arr_t ks_words
);

  typedef enum logic [2:0] {
    CS_IDLE  = 3'b001,
    CS_ROUND = 3'b010,
    CS_ADD   = 3'b100
  } core_state_t;

  core_state_t        state_r, state_nxt;
  logic [ROUND_W-1:0] round_r, round_nxt;
  word_arr_t          st_r, st_nxt;
  word_arr_t          ks_r;
  logic               diag;
  logic [3:0][31:0]   qa, qb, qc, qd, ra, rb, rc, rd;

  // Odd rounds work on diagonals, even rounds on columns.
  assign diag = round_r[0];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      qa[k] = st_r[k];
      qb[k] = st_r[4 + ((k + (diag ? 1 : 0)) & 3)];
      qc[k] = st_r[8 + ((k + (diag ? 2 : 0)) & 3)];
      qd[k] = st_r[12 + ((k + (diag ? 3 : 0)) & 3)];
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_lane
    cc20_qr u_qr (
      .a_in (qa[g]),
      .b_in (qb[g]),
      .c_in (qc[g]),
      .d_in (qd[g]),
      .a_out(ra[g]),
      .b_out(rb[g]),
      .c_out(rc[g]),
      .d_out(rd[g])
    );
  end

  always_comb begin
    st_nxt = st_r;
    for (int k = 0; k < 4; k++) begin
      st_nxt[k]                                   = ra[k];
      st_nxt[4 + ((k + (diag ? 1 : 0)) & 3)]      = rb[k];
      st_nxt[8 + ((k + (diag ? 2 : 0)) & 3)]      = rc[k];
      st_nxt[12 + ((k + (diag ? 3 : 0)) & 3)]     = rd[k];
    end
  end

  always_comb begin
    state_nxt = state_r;
    round_nxt = round_r;
    unique case (state_r)
      CS_IDLE: begin
        if (start) begin
          state_nxt = CS_ROUND;
          round_nxt = '0;
        end
      end
      CS_ROUND: begin
        round_nxt = round_r + 1'b1;
        if (round_r == ROUND_W'(ROUNDS - 1)) begin
          state_nxt = CS_ADD;
        end
      end
      CS_ADD: begin
        state_nxt = CS_IDLE;
      end
      default: begin
        state_nxt = CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_IDLE;
      round_r <= '0;
    end else begin
      state_r <= state_nxt;
      round_r <= round_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == CS_IDLE && start) begin
      st_r <= init_words;
    end else if (state_r == CS_ROUND) begin
      st_r <= st_nxt;
    end
    // Add the input block back in once the rounds are done.
    if (state_r == CS_ADD) begin
      for (int i = 0; i < 16; i++) begin
        ks_r[i] <= st_r[i] + init_words[i];
      end
    end
  end

  assign sts.busy = (state_r != CS_IDLE);
  assign sts.done = (state_r == CS_ADD);
  assign ks_words = ks_r;

endmodule

>>> rtl/core/cc20_merge.sv
module cc20_merge
  import cc20_pkg::*;
(
  input  word_arr_t   ks_words,
  input  logic [63:0] data,
  input  logic [63:0] res_in,
  input  logic [5:0]  pos,
  input  logic [3:0]  done_cnt,
  input  logic [3:0]  byte_cnt,
  output logic [63:0] res_out,
  output logic [3:0]  take
);

  logic [63:0][7:0] ks_bytes;
  logic [3:0]       rem;
  logic [6:0]       avail;
  logic [6:0]       idx [DATA_BYTES];
  logic             sel [DATA_BYTES];

  assign ks_bytes = ks_words;
  assign rem      = byte_cnt - done_cnt;
  assign avail    = 7'(BLOCK_BYTES) - {1'b0, pos};
  assign take     = (avail < {3'b000, rem}) ? avail[3:0] : rem;

  // Each byte lane picks its keystream byte and keeps or drops it.
  always_comb begin
    res_out = res_in;
    for (int j = 0; j < DATA_BYTES; j++) begin
      idx[j] = {1'b0, pos} + 7'(j) - {3'b000, done_cnt};
      sel[j] = (4'(j) >= done_cnt) && (4'(j) < byte_cnt) && !idx[j][6];
      if (sel[j]) begin
        res_out[8*j +: 8] = data[8*j +: 8] ^ ks_bytes[idx[j][5:0]];
      end
    end
  end

endmodule

>>> rtl/core/chacha20_stream_xor_top.sv
// ChaCha20 stream XOR, one 8-byte word in, one word out.
// A word is registered on accept and, while a keystream block is held, goes to the output register;
//   a word that needs a new block waits for it (load, 20 rounds, add-back).
// Throughput: one word per cycle inside a block while the output register is free; new blocks
//   come from the round engine of four quarter-round lanes, one round a cycle.
// Reset: synchronous active-low rst_n clears registers, counter, position and block flag.
module chacha20_stream_xor_top
  import cc20_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_in,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_data_out,
  output logic [3:0]  out_bytes_out,
  output logic        out_last_out,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata
);

  logic [63:0] key_low_r, key_mid_low_r, key_mid_high_r, key_high_r, nonce_low_r;
  logic [31:0] nonce_high_r, init_ctr_r;

  logic [31:0] blk_ctr_r;
  logic [5:0]  pos_r;
  logic        ks_ready_r;

  logic        item_valid_r;
  logic [63:0] data_r, res_r;
  logic [3:0]  count_r, done_r;
  logic        last_r;

  logic        out_valid_r;
  logic [63:0] out_data_r;
  logic [3:0]  out_bytes_r;
  logic        out_last_r;

  word_arr_t   init_words, ks_words;
  core_sts_t   core_sts;
  logic        gen_start;
  logic [63:0] res_nxt;
  logic [3:0]  take;
  logic [3:0]  done_nxt;
  logic [6:0]  pos_sum;
  logic        finish, out_free, commit, accept;
  logic [3:0]  count_eff;

  assign init_words = {nonce_high_r, nonce_low_r[63:32], nonce_low_r[31:0], blk_ctr_r,
                       key_high_r[63:32], key_high_r[31:0],
                       key_mid_high_r[63:32], key_mid_high_r[31:0],
                       key_mid_low_r[63:32], key_mid_low_r[31:0],
                       key_low_r[63:32], key_low_r[31:0],
                       SIGMA3, SIGMA2, SIGMA1, SIGMA0};

  assign gen_start = item_valid_r && !ks_ready_r && !core_sts.busy;

  cc20_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (gen_start),
    .init_words(init_words),
    .sts       (core_sts),
    .ks_words  (ks_words)
  );

  cc20_merge u_merge (
    .ks_words(ks_words),
    .data    (data_r),
    .res_in  (res_r),
    .pos     (pos_r),
    .done_cnt(done_r),
    .byte_cnt(count_r),
    .res_out (res_nxt),
    .take    (take)
  );

  assign done_nxt = done_r + take;
  assign pos_sum  = {1'b0, pos_r} + {3'b000, take};
  assign finish   = (done_nxt == count_r);
  assign out_free = !out_valid_r || out_ready;
  // Hold the last part of a word until the output register is free.
  assign commit   = item_valid_r && ks_ready_r && (!finish || out_free);
  assign in_ready = !item_valid_r || (commit && finish);
  assign accept   = in_valid && in_ready;

  assign count_eff = (!in_last || in_byte_count == 4'd0 ||
                      in_byte_count > 4'(BYTES_PER_ITEM)) ? 4'(BYTES_PER_ITEM)
                                                          : in_byte_count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_low_r      <= '0;
      key_mid_low_r  <= '0;
      key_mid_high_r <= '0;
      key_high_r     <= '0;
      nonce_low_r    <= '0;
      nonce_high_r   <= '0;
      init_ctr_r     <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_KEY_LOW:      key_low_r      <= cfg_wdata;
        CFG_KEY_MID_LOW:  key_mid_low_r  <= cfg_wdata;
        CFG_KEY_MID_HIGH: key_mid_high_r <= cfg_wdata;
        CFG_KEY_HIGH:     key_high_r     <= cfg_wdata;
        CFG_NONCE_LOW:    nonce_low_r    <= cfg_wdata;
        CFG_NONCE_HIGH:   nonce_high_r   <= cfg_wdata[31:0];
        CFG_INIT_CTR:     init_ctr_r     <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_ctr_r    <= '0;
      pos_r        <= '0;
      ks_ready_r   <= 1'b0;
      item_valid_r <= 1'b0;
      done_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // A first word restarts the stream and overrides the old word's advance.
      if (accept && in_first) begin
        blk_ctr_r  <= init_ctr_r;
        pos_r      <= '0;
        ks_ready_r <= 1'b0;
      end else if (core_sts.done) begin
        blk_ctr_r  <= blk_ctr_r + 32'd1;
        ks_ready_r <= 1'b1;
      end else if (commit) begin
        if (pos_sum[6]) begin
          pos_r      <= '0;
          ks_ready_r <= 1'b0;
        end else begin
          pos_r <= pos_sum[5:0];
        end
      end
      if (accept) begin
        item_valid_r <= 1'b1;
        done_r       <= '0;
      end else if (commit) begin
        done_r <= done_nxt;
        if (finish) begin
          item_valid_r <= 1'b0;
        end
      end
      if (commit && finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data_r  <= in_data_in;
      res_r   <= '0;
      count_r <= count_eff;
      last_r  <= in_last;
    end else if (commit) begin
      res_r <= res_nxt;
    end
    if (commit && finish) begin
      out_data_r  <= res_nxt;
      out_bytes_r <= count_r;
      out_last_r  <= last_r;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data_out  = out_data_r;
  assign out_bytes_out = out_bytes_r;
  assign out_last_out  = out_last_r;

`include "chacha20_stream_xor_top_assert.svh"

  `CC20_ASSERT_IMP(a_start_needs_block, gen_start, item_valid_r && !ks_ready_r, "gen without need")
  `CC20_ASSERT_NXT(a_done_sets_ready, core_sts.done, ks_ready_r, "block done but flag clear")
  `CC20_ASSERT_IMP(a_ready_core_idle, ks_ready_r, !core_sts.busy, "block held while core runs")
  `CC20_ASSERT_IMP(a_done_bound, item_valid_r, done_r < count_r, "word progress past count")

endmodule

>>> verif/chacha20_stream_xor_checker.sv
module chacha20_stream_xor_checker
  import cc20_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_data_in,
  input  logic [3:0]  in_byte_count,
  input  logic        in_first,
  input  logic        in_last,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_data_out,
  input  logic [3:0]  out_bytes_out,
  input  logic        out_last_out,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_wdata,
  output int          fail_count,
  output int          pending,
  output int          words_checked,
  output int          blocks_made
);

  typedef struct {
    logic [63:0] data;
    logic [3:0]  nbytes;
    logic        last;
  } cipher_word_t;

  cipher_word_t ciphertext_q[$];

  // Register copies
  logic [63:0] key_lo, key_ml, key_mh, key_hi, nonce_lo;
  logic [31:0] nonce_hi, ctr_init;

  // Keystream state
  logic [31:0] blk_ctr;
  logic [31:0] ks_word [16];
  logic [5:0]  ks_pos;
  logic        ks_held;

  logic [31:0] seed [16];
  logic [31:0] mix  [16];

  initial begin
    fail_count    = 0;
    words_checked = 0;
    blocks_made   = 0;
    pending       = 0;
  end

  function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void qround(input int a, input int b, input int c, input int d);
    mix[a] = mix[a] + mix[b];  mix[d] = rotl(mix[d] ^ mix[a], 16);
    mix[c] = mix[c] + mix[d];  mix[b] = rotl(mix[b] ^ mix[c], 12);
    mix[a] = mix[a] + mix[b];  mix[d] = rotl(mix[d] ^ mix[a], 8);
    mix[c] = mix[c] + mix[d];  mix[b] = rotl(mix[b] ^ mix[c], 7);
  endfunction

  // Build the next 64-byte block from the current registers and counter.
  function automatic void refill_keystream();
    seed[0]  = SIGMA0;
    seed[1]  = SIGMA1;
    seed[2]  = SIGMA2;
    seed[3]  = SIGMA3;
    seed[4]  = key_lo[31:0];
    seed[5]  = key_lo[63:32];
    seed[6]  = key_ml[31:0];
    seed[7]  = key_ml[63:32];
    seed[8]  = key_mh[31:0];
    seed[9]  = key_mh[63:32];
    seed[10] = key_hi[31:0];
    seed[11] = key_hi[63:32];
    seed[12] = blk_ctr;
    seed[13] = nonce_lo[31:0];
    seed[14] = nonce_lo[63:32];
    seed[15] = nonce_hi;
    for (int i = 0; i < 16; i++) mix[i] = seed[i];
    for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
      qround(0, 4, 8, 12);
      qround(1, 5, 9, 13);
      qround(2, 6, 10, 14);
      qround(3, 7, 11, 15);
      qround(0, 5, 10, 15);
      qround(1, 6, 11, 12);
      qround(2, 7, 8, 13);
      qround(3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_word[i] = mix[i] + seed[i];
    blk_ctr = blk_ctr + 32'd1;
    ks_held = 1'b1;
    blocks_made++;
  endfunction

  function automatic cipher_word_t encrypt_word(input logic [63:0] data,
                                                input logic [3:0]  cnt,
                                                input logic        first,
                                                input logic        last);
    cipher_word_t r;
    int           n;
    logic [7:0]   ks_byte;
    if (first) begin
      blk_ctr = ctr_init;
      ks_pos  = '0;
      ks_held = 1'b0;
    end
    // Only a last word may be short; bad counts mean a full word.
    if (!last || cnt == 0 || cnt > BYTES_PER_ITEM) n = BYTES_PER_ITEM;
    else n = cnt;
    r.data = '0;
    for (int i = 0; i < n; i++) begin
      if (!ks_held) refill_keystream();
      ks_byte = 8'(ks_word[ks_pos[5:2]] >> (8 * ks_pos[1:0]));
      r.data[8*i +: 8] = data[8*i +: 8] ^ ks_byte;
      ks_pos = ks_pos + 6'd1;
      if (ks_pos == 6'd0) ks_held = 1'b0;
    end
    r.nbytes = 4'(n);
    r.last   = last;
    return r;
  endfunction

  always @(posedge clk) begin
    cipher_word_t want;
    if (!rst_n) begin
      key_lo   = '0;
      key_ml   = '0;
      key_mh   = '0;
      key_hi   = '0;
      nonce_lo = '0;
      nonce_hi = '0;
      ctr_init = '0;
      blk_ctr  = '0;
      ks_pos   = '0;
      ks_held  = 1'b0;
      ciphertext_q.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (ciphertext_q.size() == 0) begin
          $error("word out with nothing expected: data_out %h", out_data_out);
          fail_count++;
        end else begin
          want = ciphertext_q.pop_front();
          words_checked++;
          if (out_data_out !== want.data) begin
            $error("data_out mismatch: expected %h, actual %h", want.data, out_data_out);
            fail_count++;
          end
          if (out_bytes_out !== want.nbytes) begin
            $error("bytes_out mismatch: expected %0d, actual %0d", want.nbytes, out_bytes_out);
            fail_count++;
          end
          if (out_last_out !== want.last) begin
            $error("last_out mismatch: expected %b, actual %b", want.last, out_last_out);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready)
        ciphertext_q.push_back(encrypt_word(in_data_in, in_byte_count, in_first, in_last));
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_KEY_LOW:      key_lo   = cfg_wdata;
          CFG_KEY_MID_LOW:  key_ml   = cfg_wdata;
          CFG_KEY_MID_HIGH: key_mh   = cfg_wdata;
          CFG_KEY_HIGH:     key_hi   = cfg_wdata;
          CFG_NONCE_LOW:    nonce_lo = cfg_wdata;
          CFG_NONCE_HIGH:   nonce_hi = cfg_wdata[31:0];
          CFG_INIT_CTR:     ctr_init = cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
    pending <= ciphertext_q.size();
  end

endmodule

>>> verif/chacha20_stream_xor_top_tb.sv
module chacha20_stream_xor_top_tb;
  import cc20_pkg::*;

  localparam int         CYCLE_LIMIT     = 1_000_000;
  localparam int         LONG_HOLD       = 400;
  localparam int         SETTLE          = 30;
  localparam int         PHASES          = 8;
  localparam int         WORDS_PER_PHASE = 250;
  localparam int         NUM_REGS        = CFG_INIT_CTR + 1;
  localparam logic [2:0] CFG_NO_REG      = 3'd7;

  typedef enum logic [1:0] {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;
  typedef enum logic [1:0] {ST_RANDOM, ST_ZERO, ST_ONES} cfg_style_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] in_data_in;
  logic [3:0]  in_byte_count;
  logic        in_first;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [63:0] out_data_out;
  logic [3:0]  out_bytes_out;
  logic        out_last_out;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [63:0] cfg_wdata;

  int fail_count, pending, words_checked, blocks_made;

  int          cycle_cnt     = 0;
  int          messages_sent = 0;
  int          settings_used = 0;
  int          hold_cycles   = 0;
  int          burst_left    = 0;
  bit          hold_req      = 1'b0;
  bit          offering      = 1'b0;
  logic [63:0] cfg_image [NUM_REGS];

  always #5 clk = ~clk;

  chacha20_stream_xor_top dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_in    (in_data_in),
    .in_byte_count (in_byte_count),
    .in_first      (in_first),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_out  (out_data_out),
    .out_bytes_out (out_bytes_out),
    .out_last_out  (out_last_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  chacha20_stream_xor_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_in    (in_data_in),
    .in_byte_count (in_byte_count),
    .in_first      (in_first),
    .in_last       (in_last),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data_out  (out_data_out),
    .out_bytes_out (out_bytes_out),
    .out_last_out  (out_last_out),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .blocks_made   (blocks_made)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_cnt, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: random stall patterns, plus one long hold-off on request.
  initial begin
    rx_mode_t mode;
    int       left;
    mode = RX_ALWAYS;
    left = 0;
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_cycles += LONG_HOLD;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(0, 3));
          left = $urandom_range(20, 200);
        end
        left--;
        case (mode)
          RX_ALWAYS: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
          default:   out_ready <= (cycle_cnt % 3 != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  task automatic offer_word(input logic [63:0] data, input logic [3:0] cnt,
                            input logic first, input logic last);
    int gap;
    in_valid      <= 1'b1;
    in_data_in    <= data;
    in_byte_count <= cnt;
    in_first      <= first;
    in_last       <= last;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        offering = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_message(input int n_words, input bit start);
    logic [3:0] cnt;
    for (int w = 0; w < n_words; w++) begin
      cnt = 4'($urandom_range(0, 15));
      if (w == n_words - 1 && $urandom_range(0, 4) != 0) cnt = 4'($urandom_range(1, 8));
      offer_word({$urandom, $urandom}, cnt, start && w == 0, w == n_words - 1);
    end
    messages_sent++;
  endtask

  // Drop valid, wait for every expected word, then let the round engine settle.
  task automatic wait_idle();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic load_config();
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_wdata <= cfg_image[i];
      @(posedge clk);
    end
    // an index past the map must not disturb any register
    cfg_index <= CFG_NO_REG;
    cfg_wdata <= {$urandom, $urandom};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  task automatic pick_config(input cfg_style_t style);
    for (int i = 0; i < NUM_REGS; i++) begin
      case (style)
        ST_ZERO: cfg_image[i] = '0;
        ST_ONES: cfg_image[i] = '1;
        default: cfg_image[i] = {$urandom, $urandom};
      endcase
    end
    // start near the top half the time so longer messages wrap the counter
    if ($urandom_range(0, 1))
      cfg_image[CFG_INIT_CTR] = {$urandom, 32'hFFFF_FFFF - 32'($urandom_range(0, 3))};
    load_config();
  endtask

  initial begin
    int         sent;
    int         n;
    cfg_style_t style;
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    in_data_in    <= '0;
    in_byte_count <= '0;
    in_first      <= 1'b0;
    in_last       <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_index     <= CFG_KEY_LOW;
    cfg_wdata     <= '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers, no first flag: stream runs from counter zero.
    offer_word(64'h0, 4'd0, 1'b0, 1'b0);
    offer_word('1, 4'd15, 1'b0, 1'b0);
    offer_word({$urandom, $urandom}, 4'd1, 1'b0, 1'b1);
    offer_word('1, 4'd0, 1'b0, 1'b1);
    offer_word({$urandom, $urandom}, 4'd9, 1'b1, 1'b1);
    offer_word({$urandom, $urandom}, 4'd8, 1'b0, 1'b0);
    offer_word({$urandom, $urandom}, 4'd3, 1'b1, 1'b0);
    offer_word('1, 4'd15, 1'b0, 1'b1);
    wait_idle();

    // All-ones registers, counter at the top: the message crosses the wrap.
    for (int i = 0; i < NUM_REGS; i++) cfg_image[i] = '1;
    load_config();
    send_message(17, 1'b1);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p % 4)
        1:       style = ST_ZERO;
        2:       style = ST_ONES;
        default: style = ST_RANDOM;
      endcase
      pick_config(style);
      if (p == 2) hold_req = 1'b1;
      sent = 0;
      while (sent < WORDS_PER_PHASE) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        // phase 3 opens by carrying on the old stream under the new registers
        if (sent == 0) send_message(n, p != 3);
        else send_message(n, $urandom_range(0, 6) != 0);
        sent += n;
      end
    end
    wait_idle();

    $display("covered %0d words in %0d messages under %0d register settings, %0d keystream blocks",
             words_checked, messages_sent, settings_used, blocks_made);
    $display("receiver held off for %0d cycles while words kept coming; %0d cycles in all",
             hold_cycles, cycle_cnt);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
